// ===== rtl/gyro_heading_integrator_core_defines.svh =====
// Assertion macros for the heading integrator.
`ifndef GYRO_HEADING_INTEGRATOR_CORE_DEFINES_SVH
`define GYRO_HEADING_INTEGRATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GHI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GHI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ghi_pkg.sv =====
`timescale 1ns / 1ps

package ghi_pkg;

    localparam int DIV_NUM_W  = 40;
    localparam int DIV_DEN_W  = 17;
    localparam int DIV_CNT_W  = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_NUM_W);

    localparam logic [40:0] FULL_TURN     = 41'd360 << 32;
    localparam logic [56:0] HI_SAT_LIMIT  = 57'd360 << 24;
    localparam logic [15:0] DEFAULT_SAMPLES = 16'd500;
    localparam logic [31:0] RESET_SCALE   = 32'd2152870;

    localparam logic KIND_RATE  = 1'b0;
    localparam logic KIND_CALIB = 1'b1;

    localparam logic CFG_IDX_SAMPLES = 1'b0;
    localparam logic CFG_IDX_SCALE   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CAL_CHK,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MUL_A,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SCALE,
        ST_ADD,
        ST_WRAP,
        ST_EMIT
    } t_state;

endpackage

// ===== rtl/ghi_mul.sv =====
`timescale 1ns / 1ps

// Shared 32x32 unsigned multiplier, product registered.
module ghi_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= {32'b0, i_a} * {32'b0, i_b};
    end

    assign o_p = r_p;

endmodule

// ===== rtl/ghi_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module ghi_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [ghi_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [ghi_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                           o_done,
    output logic [ghi_pkg::DIV_NUM_W-1:0]  o_quot
);

    import ghi_pkg::*;

    logic [DIV_NUM_W-1:0] r_num;   // numerator bits out, quotient bits in
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;

    logic [DIV_DEN_W:0]   w_rem_sh;
    logic [DIV_DEN_W:0]   w_rem_sub;
    logic                 w_ge;

    assign w_rem_sh  = {r_rem, r_num[DIV_NUM_W-1]};
    assign w_ge      = w_rem_sh >= {1'b0, r_den};
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= DIV_STEPS;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_rem_sub[DIV_DEN_W-1:0] : w_rem_sh[DIV_DEN_W-1:0];
            r_num <= {r_num[DIV_NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

// ===== rtl/gyro_heading_integrator_core.sv =====
`timescale 1ns / 1ps
// Per item, accept to result valid: begin-calibration, a first sample or a backwards
// timestamp pass DECODE and EMIT; a calibration sample adds CAL_CHK; an integrating
// sample runs MUL_A, MUL_LO, MUL_HI, SCALE, ADD and WRAP; the calibration sample that
// closes the run adds DIV_GO and DIV_WAIT (divider). One item at a time; a stalled output
// holds EMIT. Reset (synchronous, active low): yaw, bias, time, calibration state cleared,
// registers to defaults (500 samples, scale 2152870), output empty.

module gyro_heading_integrator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port: index 0 calib_samples, 1 rate_scale
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // [15:0] rate_z, [47:16] timestamp_us
    input  logic        i_s_axis_tuser,   // [0] kind
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // [40:0] heading, [64:41] bias, [71:65] zero
    output logic [1:0]  o_m_axis_tuser    // [0] calibrating, [1] integrated
);

    import ghi_pkg::*;

    `include "gyro_heading_integrator_core_defines.svh"

    // ---------------------------------------------------------------
    // Sequencer state and registers
    // ---------------------------------------------------------------
    t_state r_state, n_state;

    logic [15:0]        r_cfg_samples;
    logic [31:0]        r_cfg_scale;

    // tracking state
    logic [40:0]        r_yaw;
    logic signed [23:0] r_bias;
    logic [31:0]        r_last_time;
    logic               r_cal_mode;
    logic [32:0]        r_cal_sum;     // two's complement
    logic [15:0]        r_cal_count;
    logic               r_integ;

    // captured transaction
    logic               r_kind;
    logic [15:0]        r_rate;
    logic [31:0]        r_ts;

    // working registers
    logic [24:0]        r_mag;         // |rate*256 - bias|
    logic               r_neg;
    logic [31:0]        r_dt;
    logic [24:0]        r_a_hi;        // (mag*dt) >> 32
    logic [39:0]        r_lo_sh;       // (lo product) >> 24
    logic [40:0]        r_inc;
    logic [42:0]        r_y;           // signed yaw before wrap
    logic               r_sum_neg;
    logic [31:0]        r_sum_mag;
    logic [16:0]        r_den;

    // output register
    logic               r_out_valid;
    logic [40:0]        r_out_heading;
    logic [23:0]        r_out_bias;
    logic               r_out_cal;
    logic               r_out_integ;

    // control decodes
    logic               w_in_ready;
    logic               w_in_accept;
    logic               w_out_load;
    logic               w_div_start;
    logic [31:0]        w_mul_a;
    logic [31:0]        w_mul_b;

    // shared units
    logic [63:0]        w_mul_p;
    logic               w_div_done;
    logic [39:0]        w_div_quot;
    logic [39:0]        w_div_num;

    // combinational datapath terms
    logic [25:0]        w_diff;
    logic [25:0]        w_diff_neg;
    logic [32:0]        w_sum_next;
    logic [15:0]        w_count_next;
    logic [15:0]        w_n_eff;
    logic               w_cal_close;
    logic [32:0]        w_sum_abs;
    logic               w_hi_sat;
    logic [41:0]        w_scaled;
    logic [40:0]        w_inc;
    logic [23:0]        w_quot_lo;
    logic               w_ts_skip;

    assign w_in_accept = i_s_axis_tvalid && w_in_ready;

    // ---------------------------------------------------------------
    // Shared multiplier: mag*dt, then low and high halves times scale
    // ---------------------------------------------------------------
    ghi_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    // Divider for the bias mean, rounded half away from zero
    assign w_div_num = {r_sum_mag, 8'b0} + {23'b0, (r_den >> 1)};

    ghi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // ---------------------------------------------------------------
    // Datapath terms
    // ---------------------------------------------------------------
    assign w_diff     = {{2{r_rate[15]}}, r_rate, 8'b0} - {{2{r_bias[23]}}, r_bias};
    assign w_diff_neg = -w_diff;
    assign w_sum_next = r_cal_sum + {{17{r_rate[15]}}, r_rate};
    assign w_count_next = r_cal_count + 16'd1;
    assign w_ts_skip  = (r_last_time == '0) || (r_ts < r_last_time);

    // a zero count register means the default; a wrapped count closes the run too
    assign w_n_eff     = (r_cfg_samples == '0) ? DEFAULT_SAMPLES : r_cfg_samples;
    assign w_cal_close = (r_cal_count >= w_n_eff) || (r_cal_count == '0);
    assign w_sum_abs   = r_cal_sum[32] ? -r_cal_sum : r_cal_sum;

    // increment = min(floor(mag*dt*scale / 2^24), full turn)
    assign w_hi_sat = w_mul_p[56:0] > HI_SAT_LIMIT;
    assign w_scaled = {1'b0, w_mul_p[32:0], 8'b0} + {2'b0, r_lo_sh};
    assign w_inc    = (w_hi_sat || (w_scaled > {1'b0, FULL_TURN})) ? FULL_TURN
                                                                   : w_scaled[40:0];

    assign w_quot_lo = w_div_quot[23:0];

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                if (r_kind == KIND_CALIB) n_state = ST_EMIT;
                else if (r_cal_mode)      n_state = ST_CAL_CHK;
                else if (w_ts_skip)       n_state = ST_EMIT;
                else                      n_state = ST_MUL_A;
            end
            ST_CAL_CHK:  n_state = w_cal_close ? ST_DIV_GO : ST_EMIT;
            ST_DIV_GO:   n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (w_div_done) n_state = ST_EMIT;
            end
            ST_MUL_A:    n_state = ST_MUL_LO;
            ST_MUL_LO:   n_state = ST_MUL_HI;
            ST_MUL_HI:   n_state = ST_SCALE;
            ST_SCALE:    n_state = ST_ADD;
            ST_ADD:      n_state = ST_WRAP;
            ST_WRAP:     n_state = ST_EMIT;
            ST_EMIT: begin
                if (!r_out_valid || i_m_axis_tready) n_state = ST_IDLE;
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer outputs
    // ---------------------------------------------------------------
    always_comb begin
        w_in_ready  = 1'b0;
        w_out_load  = 1'b0;
        w_div_start = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        case (r_state)
            ST_IDLE:   w_in_ready = 1'b1;
            ST_DIV_GO: w_div_start = 1'b1;
            ST_MUL_A: begin
                w_mul_a = {7'b0, r_mag};
                w_mul_b = r_dt;
            end
            ST_MUL_LO: begin
                w_mul_a = w_mul_p[31:0];
                w_mul_b = r_cfg_scale;
            end
            ST_MUL_HI: begin
                w_mul_a = {7'b0, r_a_hi};
                w_mul_b = r_cfg_scale;
            end
            ST_EMIT:   w_out_load = !r_out_valid || i_m_axis_tready;
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_samples <= DEFAULT_SAMPLES;
            r_cfg_scale   <= RESET_SCALE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDX_SAMPLES: r_cfg_samples <= i_cfg_wdata[15:0];
                CFG_IDX_SCALE:   r_cfg_scale   <= i_cfg_wdata;
                default:         r_cfg_scale   <= r_cfg_scale;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Tracking and calibration state
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw       <= '0;
            r_bias      <= '0;
            r_last_time <= '0;
            r_cal_mode  <= 1'b0;
            r_cal_sum   <= '0;
            r_cal_count <= '0;
            r_integ     <= 1'b0;
        end else begin
            case (r_state)
                ST_DECODE: begin
                    r_integ <= 1'b0;
                    if (r_kind == KIND_CALIB) begin
                        r_cal_sum   <= '0;
                        r_cal_count <= '0;
                        r_bias      <= '0;
                        r_cal_mode  <= 1'b1;
                    end else if (r_cal_mode) begin
                        r_cal_sum   <= w_sum_next;
                        r_cal_count <= w_count_next;
                    end else begin
                        // first sample or backwards time only records the time
                        r_last_time <= r_ts;
                    end
                end
                ST_DIV_WAIT: begin
                    if (w_div_done) begin
                        r_bias      <= r_sum_neg ? -w_quot_lo : w_quot_lo;
                        r_yaw       <= '0;
                        r_last_time <= '0;
                        r_cal_mode  <= 1'b0;
                    end
                end
                ST_WRAP: begin
                    // one wrap into [0, 360) is enough: |inc| <= full turn
                    if (!r_y[42] && (r_y >= {2'b0, FULL_TURN})) begin
                        r_yaw <= 41'(r_y - {2'b0, FULL_TURN});
                    end else if (r_y[42]) begin
                        r_yaw <= 41'(r_y + {2'b0, FULL_TURN});
                    end else begin
                        r_yaw <= r_y[40:0];
                    end
                    r_integ <= 1'b1;
                end
                default: begin
                    r_integ <= r_integ;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Working registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_kind <= i_s_axis_tuser;
            r_rate <= i_s_axis_tdata[15:0];
            r_ts   <= i_s_axis_tdata[47:16];
        end
        case (r_state)
            ST_DECODE: begin
                r_dt  <= r_ts - r_last_time;
                r_neg <= w_diff[25];
                r_mag <= w_diff[25] ? w_diff_neg[24:0] : w_diff[24:0];
            end
            ST_CAL_CHK: begin
                r_sum_neg <= r_cal_sum[32];
                r_sum_mag <= w_sum_abs[31:0];
                r_den     <= (r_cal_count == '0) ? 17'h10000 : {1'b0, r_cal_count};
            end
            ST_MUL_LO: r_a_hi  <= w_mul_p[56:32];
            ST_MUL_HI: r_lo_sh <= w_mul_p[63:24];
            ST_SCALE:  r_inc   <= w_inc;
            ST_ADD: begin
                r_y <= r_neg ? ({2'b0, r_yaw} - {2'b0, r_inc})
                             : ({2'b0, r_yaw} + {2'b0, r_inc});
            end
            default: begin
                r_dt <= r_dt;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Output register: the next transaction may enter while it waits
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_heading <= r_yaw;
            r_out_bias    <= r_bias;
            r_out_cal     <= r_cal_mode;
            r_out_integ   <= r_integ;
        end
    end

    assign o_s_axis_tready = w_in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_out_bias, r_out_heading};
    assign o_m_axis_tuser  = {r_out_integ, r_out_cal};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `GHI_ASSERT_NOW(a_heading_range, r_out_valid, r_out_heading < FULL_TURN,
        "heading out of range")
    `GHI_ASSERT_NOW(a_integ_not_cal, r_out_valid && r_out_integ, !r_out_cal,
        "integrated result while calibrating")
    `GHI_ASSERT_NEXT(a_busy_after_accept, w_in_accept, !o_s_axis_tready,
        "ready right after accept")
    `GHI_ASSERT_NOW(a_div_done_state, w_div_done, r_state == ST_DIV_WAIT,
        "divider finished outside wait state")

endmodule
